@@ sv/cpc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cpc_pkg: shared types and constants of the convex polygon clipper
// vertex format, datapath command and status words, arithmetic widths
// ----------------------------------------------------------------------------
package cpc_pkg;

  localparam int MAX_VERTS = 8;
  localparam int IDX_W     = $clog2(MAX_VERTS);
  localparam int CNT_W     = $clog2(MAX_VERTS + 1);

  localparam int COORD_W   = 32;
  localparam int DIF_W     = COORD_W + 1;
  localparam int PRD_W     = 2 * DIF_W;
  localparam int CRS_W     = PRD_W + 1;
  localparam int DEN_W     = CRS_W + 1;
  localparam int NUM_W     = CRS_W + DIF_W;
  localparam int DIV_W     = NUM_W + 1;
  localparam int QUO_W     = DIF_W + 1;
  localparam int SUM_W     = QUO_W + 2;
  localparam int ITER_W    = $clog2(QUO_W + 1);

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t y;
    coord_t x;
  } vtx_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_WSUB,
    OP_WCLP,
    OP_COPY,
    OP_EINIT,
    OP_ENEXT,
    OP_MUL,
    OP_CROSS,
    OP_SETP,
    OP_ISECT,
    OP_PUSHI,
    OP_PUSHC,
    OP_SWAP,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [IDX_W-1:0] idx;
    logic             axis;
    logic             last;
    logic             empty;
    logic             ovf;
  } dp_cmd_t;

  typedef struct packed {
    logic cc_pos;
    logic md_done;
    logic out_busy;
  } dp_sts_t;

endpackage
`default_nettype wire

@@ sv/cpc_muldiv.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cpc_muldiv: iterative multiply then divide unit
// q = (n * m) / d, shift-add multiply then restoring division, one bit a cycle
// ----------------------------------------------------------------------------
module cpc_muldiv (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start_i,
  input  logic [cpc_pkg::CRS_W-1:0]   n_i,
  input  logic [cpc_pkg::DEN_W-1:0]   d_i,
  input  logic [cpc_pkg::DIF_W-1:0]   m_i,
  output logic                        done_o,
  output logic [cpc_pkg::QUO_W-1:0]   q_o
);
  import cpc_pkg::*;

  typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV} md_state_t;

  md_state_t         state_r;
  logic [ITER_W-1:0] cnt_r;
  logic [NUM_W-1:0]  acc_r;
  logic [NUM_W-1:0]  nsh_r;
  logic [DIF_W-1:0]  m_r;
  logic [DIV_W-1:0]  dv_r;
  logic [QUO_W-1:0]  q_r;
  logic              done_r;
  logic              ge;

  assign ge     = {1'b0, acc_r} >= dv_r;
  assign done_o = done_r;
  assign q_o    = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        MD_IDLE: begin
          if (start_i) begin
            acc_r   <= '0;
            nsh_r   <= NUM_W'(n_i);
            m_r     <= m_i;
            dv_r    <= {d_i, {(DIV_W-DEN_W){1'b0}}};
            q_r     <= '0;
            cnt_r   <= '0;
            state_r <= MD_MUL;
          end
        end
        MD_MUL: begin
          if (m_r[0]) begin
            acc_r <= acc_r + nsh_r;
          end
          nsh_r <= nsh_r << 1;
          m_r   <= m_r >> 1;
          if (cnt_r == ITER_W'(DIF_W - 1)) begin
            cnt_r   <= '0;
            state_r <= MD_DIV;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        MD_DIV: begin
          if (ge) begin
            acc_r <= acc_r - dv_r[NUM_W-1:0];
          end
          q_r  <= {q_r[QUO_W-2:0], ge};
          dv_r <= dv_r >> 1;
          if (cnt_r == ITER_W'(QUO_W - 1)) begin
            cnt_r   <= '0;
            done_r  <= 1'b1;
            state_r <= MD_IDLE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        default: state_r <= MD_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sv/cpc_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cpc_dp: clipper datapath
// vertex stores, work buffers, cross products, intersection and output word
// ----------------------------------------------------------------------------
module cpc_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [2*cpc_pkg::COORD_W-1:0] in_data_i,
  input  cpc_pkg::dp_cmd_t              cmd_i,
  output cpc_pkg::dp_sts_t              sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2*cpc_pkg::COORD_W-1:0] out_data_o,
  output logic                          out_last_o,
  output logic [1:0]                    out_user_o
);
  import cpc_pkg::*;

  vtx_t sub_mem  [MAX_VERTS];
  vtx_t clp_mem  [MAX_VERTS];
  vtx_t work_mem [2][MAX_VERTS];

  logic                    sel_r;
  vtx_t                    e0_r, e1_r, prev_r, cur_r;
  logic signed [PRD_W-1:0] p1_r, p2_r;
  logic signed [CRS_W-1:0] cc_r, cp_r;
  coord_t                  ix_r, iy_r;
  logic                    axis_r;
  logic                    out_valid_r;
  vtx_t                    out_v_r;
  logic                    out_last_r;
  logic [1:0]              out_user_r;

  vtx_t                    in_vtx, src_rd, isect_v;
  logic signed [DIF_W-1:0] ax, ay, bx, by, dlt;
  logic signed [DEN_W-1:0] den;
  logic [CRS_W-1:0]        n_mag;
  logic [DEN_W-1:0]        d_mag;
  logic [DIF_W-1:0]        m_mag;
  logic                    ax_sel, neg_off, md_done, md_start;
  logic [QUO_W-1:0]        md_q;
  coord_t                  base, ax_res, sat;
  logic signed [SUM_W-1:0] qext, sum;

  assign in_vtx  = vtx_t'(in_data_i);
  assign src_rd  = work_mem[sel_r][cmd_i.idx];
  assign isect_v = '{y: iy_r, x: ix_r};

  assign ax = DIF_W'(e1_r.x) - DIF_W'(e0_r.x);
  assign ay = DIF_W'(e1_r.y) - DIF_W'(e0_r.y);
  assign bx = DIF_W'(src_rd.x) - DIF_W'(e0_r.x);
  assign by = DIF_W'(src_rd.y) - DIF_W'(e0_r.y);

  assign den    = DEN_W'(cp_r) - DEN_W'(cc_r);
  assign n_mag  = cp_r[CRS_W-1] ? CRS_W'(-cp_r) : CRS_W'(cp_r);
  assign d_mag  = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
  assign ax_sel = (cmd_i.op == OP_ISECT) ? cmd_i.axis : axis_r;
  assign dlt    = ax_sel ? (DIF_W'(cur_r.y) - DIF_W'(prev_r.y))
                         : (DIF_W'(cur_r.x) - DIF_W'(prev_r.x));
  assign m_mag  = dlt[DIF_W-1] ? DIF_W'(-dlt) : DIF_W'(dlt);
  assign base   = ax_sel ? prev_r.y : prev_r.x;

  assign md_start = (cmd_i.op == OP_ISECT);

  cpc_muldiv u_muldiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (md_start),
    .n_i     (n_mag),
    .d_i     (d_mag),
    .m_i     (m_mag),
    .done_o  (md_done),
    .q_o     (md_q)
  );

  // offset sign from cross product, divisor and delta signs
  assign neg_off = ((cp_r[CRS_W-1] != den[DEN_W-1]) != dlt[DIF_W-1]);
  assign qext    = SUM_W'(md_q);
  assign sum     = SUM_W'(base) + (neg_off ? -qext : qext);

  always_comb begin
    if ((sum[SUM_W-1:COORD_W-1] == '0) || (sum[SUM_W-1:COORD_W-1] == '1)) begin
      sat = sum[COORD_W-1:0];
    end else if (sum[SUM_W-1]) begin
      sat = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(COORD_W-1){1'b1}}};
    end
    ax_res = (den == '0) ? base : sat;
  end

  always_ff @(posedge clk) begin
    unique case (cmd_i.op)
      OP_WSUB:  sub_mem[cmd_i.idx] <= in_vtx;
      OP_WCLP:  clp_mem[cmd_i.idx] <= in_vtx;
      OP_COPY:  work_mem[sel_r][cmd_i.idx] <= sub_mem[cmd_i.idx];
      OP_EINIT: e1_r <= clp_mem[cmd_i.idx];
      OP_ENEXT: begin
        e0_r <= e1_r;
        e1_r <= clp_mem[cmd_i.idx];
      end
      OP_MUL: begin
        cur_r <= src_rd;
        p1_r  <= ax * by;
        p2_r  <= ay * bx;
      end
      OP_CROSS: cc_r <= CRS_W'(p1_r) - CRS_W'(p2_r);
      OP_SETP: begin
        prev_r <= cur_r;
        cp_r   <= cc_r;
      end
      OP_ISECT: axis_r <= cmd_i.axis;
      OP_PUSHI: work_mem[~sel_r][cmd_i.idx] <= isect_v;
      OP_PUSHC: work_mem[~sel_r][cmd_i.idx] <= cur_r;
      OP_EMIT: begin
        out_v_r    <= cmd_i.empty ? '0 : src_rd;
        out_last_r <= cmd_i.last;
        out_user_r <= {cmd_i.ovf, cmd_i.empty};
      end
      default: ;
    endcase
    if (md_done) begin
      if (axis_r) begin
        iy_r <= ax_res;
      end else begin
        ix_r <= ax_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd_i.op == OP_SWAP) begin
        sel_r <= ~sel_r;
      end
      if (cmd_i.op == OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts_o.cc_pos   = !cc_r[CRS_W-1] && (cc_r != '0);
  assign sts_o.md_done  = md_done;
  assign sts_o.out_busy = out_valid_r && !out_ready_i;

  assign out_valid_o = out_valid_r;
  assign out_data_o  = out_v_r;
  assign out_last_o  = out_last_r;
  assign out_user_o  = out_user_r;

endmodule
`default_nettype wire

@@ sv/cpc_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cpc_ctrl: clipper sequencer
// vertex counts, stage and vertex walk, datapath command generation
// ----------------------------------------------------------------------------
module cpc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic             in_mode,
  input  logic             in_last,
  input  cpc_pkg::dp_sts_t sts_i,
  output cpc_pkg::dp_cmd_t cmd_o
);
  import cpc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_COPY, ST_EDGE0, ST_EDGE, ST_PMUL, ST_PCRS, ST_PSET,
    ST_VMUL, ST_VCRS, ST_DECIDE, ST_ISX, ST_WX, ST_ISY, ST_WY,
    ST_PUSHI, ST_PUSHC, ST_NEXT, ST_ENDST, ST_EMIT, ST_EMPTY
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] sub_cnt_r, clp_cnt_r, n_r, d_r, k_r, st_r;
  logic             sub_closed_r, clp_closed_r, pin_r, ovf_r;

  logic [CNT_W-1:0] sub_eff, clp_eff, clp_last, n_last;
  logic             accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign sub_eff   = sub_closed_r ? '0 : sub_cnt_r;
  assign clp_eff   = clp_closed_r ? '0 : clp_cnt_r;
  assign clp_last  = clp_cnt_r - 1'b1;
  assign n_last    = n_r - 1'b1;

  always_comb begin
    cmd_o = '{op: OP_NONE, idx: '0, axis: 1'b0, last: 1'b0, empty: 1'b0, ovf: ovf_r};
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_mode) begin
            if (clp_eff < CNT_W'(MAX_VERTS)) begin
              cmd_o.op  = OP_WCLP;
              cmd_o.idx = clp_eff[IDX_W-1:0];
            end
          end else if (sub_eff < CNT_W'(MAX_VERTS)) begin
            cmd_o.op  = OP_WSUB;
            cmd_o.idx = sub_eff[IDX_W-1:0];
          end
        end
      end
      ST_COPY: begin
        cmd_o.op  = OP_COPY;
        cmd_o.idx = k_r[IDX_W-1:0];
      end
      ST_EDGE0: begin
        cmd_o.op  = OP_EINIT;
        cmd_o.idx = clp_last[IDX_W-1:0];
      end
      ST_EDGE: begin
        cmd_o.op  = OP_ENEXT;
        cmd_o.idx = st_r[IDX_W-1:0];
      end
      ST_PMUL: begin
        cmd_o.op  = OP_MUL;
        cmd_o.idx = n_last[IDX_W-1:0];
      end
      ST_VMUL: begin
        cmd_o.op  = OP_MUL;
        cmd_o.idx = k_r[IDX_W-1:0];
      end
      ST_PCRS, ST_VCRS: cmd_o.op = OP_CROSS;
      ST_PSET, ST_NEXT: cmd_o.op = OP_SETP;
      ST_ISX: cmd_o.op = OP_ISECT;
      ST_ISY: begin
        cmd_o.op   = OP_ISECT;
        cmd_o.axis = 1'b1;
      end
      ST_PUSHI: begin
        if (d_r < CNT_W'(MAX_VERTS)) begin
          cmd_o.op  = OP_PUSHI;
          cmd_o.idx = d_r[IDX_W-1:0];
        end
      end
      ST_PUSHC: begin
        if (d_r < CNT_W'(MAX_VERTS)) begin
          cmd_o.op  = OP_PUSHC;
          cmd_o.idx = d_r[IDX_W-1:0];
        end
      end
      ST_ENDST: cmd_o.op = OP_SWAP;
      ST_EMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.op   = OP_EMIT;
          cmd_o.idx  = k_r[IDX_W-1:0];
          cmd_o.last = (k_r == n_last);
        end
      end
      ST_EMPTY: begin
        if (!sts_i.out_busy) begin
          cmd_o.op    = OP_EMIT;
          cmd_o.last  = 1'b1;
          cmd_o.empty = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      sub_cnt_r    <= '0;
      clp_cnt_r    <= '0;
      sub_closed_r <= 1'b0;
      clp_closed_r <= 1'b0;
      n_r          <= '0;
      d_r          <= '0;
      k_r          <= '0;
      st_r         <= '0;
      pin_r        <= 1'b0;
      ovf_r        <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (!in_mode) begin
              sub_cnt_r    <= (sub_eff < CNT_W'(MAX_VERTS)) ? sub_eff + 1'b1 : sub_eff;
              sub_closed_r <= in_last;
            end else begin
              clp_cnt_r    <= (clp_eff < CNT_W'(MAX_VERTS)) ? clp_eff + 1'b1 : clp_eff;
              clp_closed_r <= in_last;
              if (in_last) begin
                sub_closed_r <= 1'b1;
                n_r          <= sub_cnt_r;
                ovf_r        <= 1'b0;
                k_r          <= '0;
                st_r         <= '0;
                state_r      <= (sub_cnt_r == '0) ? ST_EMPTY : ST_COPY;
              end
            end
          end
        end
        ST_COPY: begin
          if (k_r == n_last) begin
            state_r <= ST_EDGE0;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        ST_EDGE0: state_r <= ST_EDGE;
        ST_EDGE: begin
          d_r     <= '0;
          state_r <= ST_PMUL;
        end
        ST_PMUL: state_r <= ST_PCRS;
        ST_PCRS: state_r <= ST_PSET;
        ST_PSET: begin
          pin_r   <= sts_i.cc_pos;
          k_r     <= '0;
          state_r <= ST_VMUL;
        end
        ST_VMUL: state_r <= ST_VCRS;
        ST_VCRS: state_r <= ST_DECIDE;
        ST_DECIDE: begin
          priority if (sts_i.cc_pos != pin_r) begin
            state_r <= ST_ISX;
          end else if (sts_i.cc_pos) begin
            state_r <= ST_PUSHC;
          end else begin
            state_r <= ST_NEXT;
          end
        end
        ST_ISX: state_r <= ST_WX;
        ST_WX: begin
          if (sts_i.md_done) begin
            state_r <= ST_ISY;
          end
        end
        ST_ISY: state_r <= ST_WY;
        ST_WY: begin
          if (sts_i.md_done) begin
            state_r <= ST_PUSHI;
          end
        end
        ST_PUSHI: begin
          if (d_r < CNT_W'(MAX_VERTS)) begin
            d_r <= d_r + 1'b1;
          end else begin
            ovf_r <= 1'b1;
          end
          state_r <= sts_i.cc_pos ? ST_PUSHC : ST_NEXT;
        end
        ST_PUSHC: begin
          if (d_r < CNT_W'(MAX_VERTS)) begin
            d_r <= d_r + 1'b1;
          end else begin
            ovf_r <= 1'b1;
          end
          state_r <= ST_NEXT;
        end
        ST_NEXT: begin
          pin_r <= sts_i.cc_pos;
          if (k_r == n_last) begin
            state_r <= ST_ENDST;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= ST_VMUL;
          end
        end
        ST_ENDST: begin
          n_r <= d_r;
          k_r <= '0;
          priority if (d_r == '0) begin
            state_r <= ST_EMPTY;
          end else if (st_r == clp_last) begin
            state_r <= ST_EMIT;
          end else begin
            st_r    <= st_r + 1'b1;
            state_r <= ST_EDGE;
          end
        end
        ST_EMIT: begin
          if (!sts_i.out_busy) begin
            if (k_r == n_last) begin
              state_r <= ST_IDLE;
            end else begin
              k_r <= k_r + 1'b1;
            end
          end
        end
        ST_EMPTY: begin
          if (!sts_i.out_busy) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sv/convex_polygon_clipper_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// convex_polygon_clipper_top: convex polygon clipper
// run: a vertex word is taken while idle; a last clipping word starts a run of
//   clipping stages, and each edge crossing waits on the shared multiply-divide
//   unit once per axis
// throughput: one run at a time, results then leave one word per cycle while out_tready is high
// reset: synchronous active-low rst_n clears counts and control, stores keep data
// ----------------------------------------------------------------------------
module convex_polygon_clipper_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [2*cpc_pkg::COORD_W-1:0] in_tdata,  // x, y
  input  logic                          in_tuser,  // mode
  input  logic                          in_tlast,  // last
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [2*cpc_pkg::COORD_W-1:0] out_tdata, // out_x, out_y
  output logic [1:0]                    out_tuser, // empty_res, overflow
  output logic                          out_tlast  // final_res
);
  import cpc_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  cpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_mode   (in_tuser),
    .in_last   (in_tlast),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  cpc_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data_i   (in_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .out_data_o  (out_tdata),
    .out_last_o  (out_tlast),
    .out_user_o  (out_tuser)
  );

endmodule
`default_nettype wire

@@ test/tb_convex_polygon_clipper_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_convex_polygon_clipper_top: testbench of the convex polygon clipper
// loads subject and clipping polygons as stream words, predicts the clipped
// polygon per run with exact wide arithmetic and checks every result word
// in order; both stream sides stall at random
// ----------------------------------------------------------------------------
module tb_convex_polygon_clipper_top;
  import cpc_pkg::*;

  localparam logic MODE_SUBJECT = 1'b0;
  localparam logic MODE_CLIPPER = 1'b1;
  localparam int   UNIT         = 65536;

  typedef struct {
    coord_t x;
    coord_t y;
  } pt_t;

  typedef pt_t pt_arr_t [MAX_VERTS];

  typedef struct {
    coord_t x;
    coord_t y;
    bit     fin;
    bit     emp;
    bit     ovf;
  } clip_word_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [2*COORD_W-1:0] in_tdata;
  logic                 in_tuser;
  logic                 in_tlast;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [2*COORD_W-1:0] out_tdata;
  logic [1:0]           out_tuser;
  logic                 out_tlast;

  pt_arr_t    subject_pts;
  pt_arr_t    clipper_pts;
  int         subject_len;
  int         clipper_len;
  bit         subject_done;
  bit         clipper_done;
  clip_word_t clipped_words[$];
  int         error_count;
  int         words_sent;
  bit         quiet;

  convex_polygon_clipper_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // exact edge-side cross product (p2 - p1) x (v - p1)
  function automatic logic signed [127:0] side_cross(pt_t p1, pt_t p2, pt_t v);
    logic signed [127:0] ax, ay, bx, by;
    ax = longint'(p2.x) - longint'(p1.x);
    ay = longint'(p2.y) - longint'(p1.y);
    bx = longint'(v.x) - longint'(p1.x);
    by = longint'(v.y) - longint'(p1.y);
    return ax * by - ay * bx;
  endfunction

  function automatic coord_t cut_axis(coord_t base, longint delta, logic signed [127:0] num,
                                      logic signed [127:0] den, bit negt);
    logic signed [127:0] q, r, mag_d;
    mag_d = (delta < 0) ? -delta : delta;
    q = (num * mag_d) / den;
    if (negt != (delta < 0)) q = -q;
    r = base + q;
    if (r < -128'sd2147483648) return 32'sh8000_0000;
    if (r > 128'sd2147483647) return 32'sh7fff_ffff;
    return r[31:0];
  endfunction

  function automatic pt_t cut_point(pt_t e0, pt_t e1, pt_t s, pt_t e);
    logic signed [127:0] cs, den;
    bit negt;
    pt_t r;
    cs  = side_cross(e0, e1, s);
    den = cs - side_cross(e0, e1, e);
    if (den == 0) return s;
    negt = (cs < 0) != (den < 0);
    if (cs < 0) cs = -cs;
    if (den < 0) den = -den;
    r.x = cut_axis(s.x, longint'(e.x) - longint'(s.x), cs, den, negt);
    r.y = cut_axis(s.y, longint'(e.y) - longint'(s.y), cs, den, negt);
    return r;
  endfunction

  function automatic int clip_by_edge(pt_t e0, pt_t e1, pt_arr_t src, int n,
                                      ref pt_arr_t dst, ref bit ovf);
    pt_t prev;
    bit  pin, cin;
    int  cnt;
    cnt = 0;
    if (n <= 0) return 0;
    prev = src[n-1];
    pin  = side_cross(e0, e1, prev) > 0;
    for (int i = 0; i < n; i++) begin
      cin = side_cross(e0, e1, src[i]) > 0;
      if (cin != pin) begin
        if (cnt < MAX_VERTS) dst[cnt++] = cut_point(e0, e1, prev, src[i]);
        else ovf = 1'b1;
      end
      if (cin) begin
        if (cnt < MAX_VERTS) dst[cnt++] = src[i];
        else ovf = 1'b1;
      end
      prev = src[i];
      pin  = cin;
    end
    return cnt;
  endfunction

  function automatic void clip_polygon();
    pt_arr_t    cur, nxt;
    pt_t        prev;
    bit         ovf;
    int         c;
    clip_word_t w;
    ovf  = 1'b0;
    cur  = subject_pts;
    c    = subject_len;
    prev = clipper_pts[clipper_len-1];
    for (int i = 0; i < clipper_len && c > 0; i++) begin
      c = clip_by_edge(prev, clipper_pts[i], cur, c, nxt, ovf);
      if (c == 0) break;
      prev = clipper_pts[i];
      cur  = nxt;
    end
    if (c == 0) begin
      w = '{x: 0, y: 0, fin: 1'b1, emp: 1'b1, ovf: ovf};
      clipped_words.push_back(w);
    end else begin
      for (int k = 0; k < c; k++) begin
        w = '{x: cur[k].x, y: cur[k].y, fin: k == c - 1, emp: 1'b0, ovf: ovf};
        clipped_words.push_back(w);
      end
    end
  endfunction

  function automatic void load_vertex(logic mode, coord_t x, coord_t y, logic last);
    pt_t v;
    v.x = x;
    v.y = y;
    if (mode == MODE_SUBJECT) begin
      if (subject_done) begin
        subject_len  = 0;
        subject_done = 1'b0;
      end
      if (subject_len < MAX_VERTS) subject_pts[subject_len++] = v;
      if (last) subject_done = 1'b1;
    end else begin
      if (clipper_done) begin
        clipper_len  = 0;
        clipper_done = 1'b0;
      end
      if (clipper_len < MAX_VERTS) clipper_pts[clipper_len++] = v;
      if (last) begin
        clipper_done = 1'b1;
        subject_done = 1'b1;
        clip_polygon();
      end
    end
  endfunction

  task automatic send_vertex(logic mode, coord_t x, coord_t y, logic last);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {y, x};
    in_tuser  <= mode;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    load_vertex(mode, x, y, last);
    words_sent++;
  endtask

  task automatic send_square(logic mode, int x0, int y0, int side);
    send_vertex(mode, x0 * UNIT, y0 * UNIT, 1'b0);
    send_vertex(mode, (x0 + side) * UNIT, y0 * UNIT, 1'b0);
    send_vertex(mode, (x0 + side) * UNIT, (y0 + side) * UNIT, 1'b0);
    send_vertex(mode, x0 * UNIT, (y0 + side) * UNIT, 1'b1);
  endtask

  always @(posedge clk) begin
    int stall;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall = 0;
    end else if (stall > 0) begin
      stall--;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall = $urandom_range(1, 13) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    clip_word_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (clipped_words.size() == 0) begin
        $display("%0t: unexpected word x=%h y=%h", $time, out_tdata[31:0], out_tdata[63:32]);
        error_count++;
      end else begin
        w = clipped_words.pop_front();
        if (out_tdata[31:0] !== w.x) begin
          $display("%0t: x expected %h actual %h", $time, w.x, out_tdata[31:0]);
          error_count++;
        end
        if (out_tdata[63:32] !== w.y) begin
          $display("%0t: y expected %h actual %h", $time, w.y, out_tdata[63:32]);
          error_count++;
        end
        if (out_tlast !== w.fin) begin
          $display("%0t: final expected %b actual %b", $time, w.fin, out_tlast);
          error_count++;
        end
        if (out_tuser[0] !== w.emp) begin
          $display("%0t: empty expected %b actual %b", $time, w.emp, out_tuser[0]);
          error_count++;
        end
        if (out_tuser[1] !== w.ovf) begin
          $display("%0t: overflow expected %b actual %b", $time, w.ovf, out_tuser[1]);
          error_count++;
        end
      end
    end
  end

  // clipping before any subject vertex gives one empty word
  task automatic test_empty_subject();
    send_vertex(MODE_CLIPPER, 0, 0, 1'b0);
    send_vertex(MODE_CLIPPER, 10 * UNIT, 0, 1'b0);
    send_vertex(MODE_CLIPPER, 0, 10 * UNIT, 1'b1);
  endtask

  task automatic test_overlap();
    send_square(MODE_SUBJECT, 0, 0, 10);
    send_square(MODE_CLIPPER, 5, 3, 10);
  endtask

  // single clipping vertex makes a null edge, old subject is reused
  task automatic test_degenerate_clipper();
    send_vertex(MODE_CLIPPER, 3 * UNIT, 3 * UNIT, 1'b1);
  endtask

  task automatic test_extremes();
    send_vertex(MODE_SUBJECT, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
    send_vertex(MODE_SUBJECT, 32'sh7fff_ffff, 32'sh8000_0000, 1'b0);
    send_vertex(MODE_SUBJECT, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b1);
    send_vertex(MODE_CLIPPER, -1, -1, 1'b0);
    send_vertex(MODE_CLIPPER, 32'sh7fff_0000, 32'sh8000_0001, 1'b0);
    send_vertex(MODE_CLIPPER, 0, 32'sh7fff_ffff, 1'b1);
  endtask

  function automatic coord_t rand_coord();
    if ($urandom_range(0, 5) == 0) return $urandom;
    return $urandom_range(0, 2 * 40 * UNIT) - 40 * UNIT;
  endfunction

  task automatic test_random();
    int     n, kind, x0, y0, w, h;
    coord_t ax, ay, bx, by, cx, cy;
    while (words_sent < 210) begin
      if (words_sent >= 180) quiet = 1'b1;
      kind = $urandom_range(0, 9);
      if (kind != 0) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 10) : $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
          send_vertex(MODE_SUBJECT, rand_coord(), rand_coord(), i == n - 1);
      end
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        x0 = $urandom_range(0, 60) - 30;
        y0 = $urandom_range(0, 60) - 30;
        w  = $urandom_range(1, 40);
        h  = $urandom_range(1, 40);
        send_vertex(MODE_CLIPPER, x0 * UNIT, y0 * UNIT, 1'b0);
        send_vertex(MODE_CLIPPER, (x0 + w) * UNIT, y0 * UNIT, 1'b0);
        send_vertex(MODE_CLIPPER, (x0 + w) * UNIT, (y0 + h) * UNIT, 1'b0);
        send_vertex(MODE_CLIPPER, x0 * UNIT, (y0 + h) * UNIT, 1'b1);
      end else if (kind < 8) begin
        ax = rand_coord();
        ay = rand_coord();
        bx = rand_coord();
        by = rand_coord();
        cx = rand_coord();
        cy = rand_coord();
        send_vertex(MODE_CLIPPER, ax, ay, 1'b0);
        if (side_cross('{ax, ay}, '{bx, by}, '{cx, cy}) < 0) begin
          send_vertex(MODE_CLIPPER, cx, cy, 1'b0);
          send_vertex(MODE_CLIPPER, bx, by, 1'b1);
        end else begin
          send_vertex(MODE_CLIPPER, bx, by, 1'b0);
          send_vertex(MODE_CLIPPER, cx, cy, 1'b1);
        end
      end else begin
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++)
          send_vertex(MODE_CLIPPER, rand_coord(), rand_coord(), i == n - 1);
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = 1'b0;
    in_tlast     = 1'b0;
    subject_len  = 0;
    clipper_len  = 0;
    subject_done = 1'b0;
    clipper_done = 1'b0;
    error_count  = 0;
    words_sent   = 0;
    quiet        = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_subject();
    test_overlap();
    test_degenerate_clipper();
    test_extremes();
    test_random();
    in_tvalid <= 1'b0;
    while (clipped_words.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (error_count == 0 && clipped_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
